// File: design/nmf_pkg.sv
// ----------------------------------------------------------------------------
// nmf_pkg
// Shared types, constants and the reciprocal table of the neighbour mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package nmf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int CH_W      = 8;
   localparam int NUM_LANES = 3;
   localparam int PIX_W     = CH_W * NUM_LANES;
   localparam int WIN_N     = 9;
   localparam int WIN_CTR   = 4;
   localparam int CNT_W     = 4;
   localparam int SUM_W     = 11;
   localparam int RCP_W     = 17;
   localparam int RCP_SHIFT = 16;
   localparam int PROD_W    = SUM_W + RCP_W;

   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } ctrl_state_type;

   typedef logic [PIX_W-1:0]            pixel_type;
   typedef logic [WIN_N-1:0][PIX_W-1:0] window_type;
   typedef logic [WIN_N-1:0][CH_W-1:0]  chan_win_type;

   typedef struct packed {
      logic             valid;
      logic [WIN_N-1:0] use_mask;
      logic [CNT_W-1:0] cnt;
      logic             last;
   } launch_type;

   // floor(2^16 / n) + 1: exact quotient for sums below 2^11
   function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
      logic [RCP_W-1:0] r;
      case (n)
         4'd1:    r = RCP_W'(65537);
         4'd2:    r = RCP_W'(32769);
         4'd3:    r = RCP_W'(21846);
         4'd4:    r = RCP_W'(16385);
         4'd5:    r = RCP_W'(13108);
         4'd6:    r = RCP_W'(10923);
         4'd7:    r = RCP_W'(9363);
         4'd8:    r = RCP_W'(8193);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/nmf_ram.sv
// ----------------------------------------------------------------------------
// nmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nmf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/nmf_ctrl.sv
// ----------------------------------------------------------------------------
// nmf_ctrl
// Frame position tracking, line stores, 3x3 window and neighbour masks.
// ----------------------------------------------------------------------------
`default_nettype none

module nmf_ctrl
   import nmf_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_cmd,
   input  wire pixel_type             req_pixel,
   input  wire logic                  launch_ready,
   output launch_type                 launch,
   output window_type                 window
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
   localparam int OROW_W = $clog2(MAX_HEIGHT);

   ctrl_state_type    state_ff, state_in;
   logic [FW_W-1:0]   fw_ff, fw_in;
   logic [FH_W-1:0]   fh_ff, fh_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [OROW_W-1:0] out_row_ff, out_row_in;
   window_type        win_ff, win_in;
   pixel_type         pix_ff, pix_in;

   logic [WID_W-1:0]  eff_w;
   logic [HGT_W-1:0]  eff_h;
   logic              input_done;
   logic              started;
   logic              go;
   logic              emit;
   logic              commit;
   logic              has_up, has_down, has_left, has_right;
   logic              last;
   logic [WIN_N-1:0]  use_mask;
   logic [CNT_W-1:0]  cnt;
   pixel_type         up_rd, mid_rd;

   nmf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (in_col_ff),
      .wr_data (mid_rd),
      .rd_en   (go),
      .rd_addr (in_col_ff),
      .rd_data (up_rd)
   );

   nmf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_middle (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (in_col_ff),
      .wr_data (pix_ff),
      .rd_en   (go),
      .rd_addr (in_col_ff),
      .rd_data (mid_rd)
   );

   always_comb begin
      if (fw_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (32'(fw_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(fw_ff);
      end
      if (fh_ff == '0) begin
         eff_h = HGT_W'(1);
      end else if (32'(fh_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = HGT_W'(MAX_HEIGHT);
      end else begin
         eff_h = HGT_W'(fh_ff);
      end
   end

   assign input_done = 32'(in_row_ff) >= 32'(eff_h);
   assign started    = (in_row_ff != '0) || (in_col_ff != '0);
   assign emit       = (32'(in_row_ff) >= 32'd2) ||
                       ((32'(in_row_ff) == 32'd1) && (in_col_ff != '0));

   assign has_up    = out_row_ff != '0;
   assign has_down  = (32'(out_row_ff) + 32'd1) < 32'(eff_h);
   assign has_left  = out_col_ff != '0;
   assign has_right = (32'(out_col_ff) + 32'd1) < 32'(eff_w);
   assign last      = !has_down && !has_right;

   always_comb begin
      use_mask[0] = has_left && has_up;
      use_mask[1] = has_left;
      use_mask[2] = has_left && has_down;
      use_mask[3] = has_up;
      use_mask[4] = 1'b0;
      use_mask[5] = has_down;
      use_mask[6] = has_right && has_up;
      use_mask[7] = has_right;
      use_mask[8] = has_right && has_down;
      cnt = '0;
      for (int i = 0; i < WIN_N; i++) begin
         cnt = cnt + CNT_W'(use_mask[i]);
      end
   end

   always_comb begin
      state_in   = state_ff;
      fw_in      = fw_ff;
      fh_in      = fh_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      win_in     = win_ff;
      pix_in     = pix_ff;
      req_ready  = 1'b0;
      go         = 1'b0;
      commit     = 1'b0;

      for (int i = 0; i < WIN_N - 3; i++) begin
         win_in[i] = win_ff[i + 3];
      end
      win_in[6] = up_rd;
      win_in[7] = mid_rd;
      win_in[8] = pix_ff;

      case (state_ff)
         ST_IDLE: begin
            win_in    = win_ff;
            req_ready = 1'b1;
            go        = req_valid &&
                        !((req_cmd == CMD_DRAIN) && (!input_done || !started));
            if (go) begin
               pix_in   = ((req_cmd == CMD_DRAIN) || input_done) ? '0 : req_pixel;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            commit = !emit || launch_ready;
            if (commit) begin
               state_in = ST_IDLE;
               if ((32'(in_col_ff) + 32'd1) >= 32'(eff_w)) begin
                  in_col_in = '0;
                  in_row_in = in_row_ff + ROW_W'(1);
               end else begin
                  in_col_in = in_col_ff + COL_W'(1);
               end
               if (emit) begin
                  if (last) begin
                     in_col_in  = '0;
                     in_row_in  = '0;
                     out_col_in = '0;
                     out_row_in = '0;
                  end else if (!has_right) begin
                     out_col_in = '0;
                     out_row_in = out_row_ff + OROW_W'(1);
                  end else begin
                     out_col_in = out_col_ff + COL_W'(1);
                  end
               end
            end else begin
               win_in = win_ff;
            end
         end
         default: begin
            win_in   = win_ff;
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_FRAME_WIDTH:  fw_in = csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: fh_in = csr_wdata[FH_W-1:0];
            default:          fw_in = fw_ff;
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fw_ff      <= FRAME_WIDTH_RST;
         fh_ff      <= FRAME_HEIGHT_RST;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         win_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         fw_ff      <= fw_in;
         fh_ff      <= fh_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         win_ff     <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   always_comb begin
      launch.valid    = commit && emit;
      launch.use_mask = use_mask;
      launch.cnt      = cnt;
      launch.last     = last;
   end

   assign window = win_in;

endmodule

`default_nettype wire

// File: design/nmf_lane.sv
// ----------------------------------------------------------------------------
// nmf_lane
// One color channel: masked neighbour sum, then mean by reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module nmf_lane
   import nmf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             en_a,
   input  wire logic             en_b,
   input  wire chan_win_type     nbr,
   input  wire logic [WIN_N-1:0] use_mask,
   input  wire logic [CNT_W-1:0] cnt,
   output logic      [CH_W-1:0]  mean
);

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CH_W-1:0]   ctr_ff;
   logic [CH_W-1:0]   mean_ff, mean_in;
   logic [PROD_W-1:0] prod;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < WIN_N; i++) begin
         if (use_mask[i]) begin
            sum_in = sum_in + SUM_W'(nbr[i]);
         end
      end
   end

   assign prod    = PROD_W'(sum_ff) * PROD_W'(recip(cnt_ff));
   assign mean_in = (cnt_ff == '0) ? ctr_ff : prod[RCP_SHIFT +: CH_W];

   always_ff @(posedge clock) begin
      if (en_a) begin
         sum_ff <= sum_in;
         cnt_ff <= cnt;
         ctr_ff <= nbr[WIN_CTR];
      end
      if (en_b) begin
         mean_ff <= mean_in;
      end
   end

   assign mean = mean_ff;

endmodule

`default_nettype wire

// File: design/neighbour_mean_filter_rgb.sv
// ----------------------------------------------------------------------------
// neighbour_mean_filter_rgb
// 3x3 neighbour mean (center excluded) over RGB raster frames, three lanes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata {blue,green,red}, tuser cmd
//  rsp     | out | rsp_tvalid/tready    | tdata {blue,green,red}, tlast frame end
//  csr     | in  | csr_we               | csr_addr index, csr_wdata value
//
//  An item that enters the window passes the control sequencer in ST_IDLE
//  (line store read), then ST_UPDATE (window shift and store write); a drain
//  that is ignored is taken in ST_IDLE alone. Lanes add a sum and a multiply
//  stage: a result passes the sum, mean and output registers in turn. Reset
//  clears positions, window and valids; the line stores are not cleared. A
//  stalled rsp holds the lane pipeline and, once it is full, the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbour_mean_filter_rgb
   import nmf_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [PIX_W-1:0]      req_tdata,   // red, green, blue
   input  wire logic                  req_tuser,   // cmd
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [PIX_W-1:0]      rsp_tdata,   // red_out, green_out, blue_out
   output logic                       rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   launch_type                launch;
   window_type                window;
   pixel_type                 req_pixel;
   logic [NUM_LANES-1:0][CH_W-1:0] mean;

   logic             a_vld_ff, b_vld_ff, rsp_vld_ff;
   logic             last_a_ff, last_b_ff, rsp_last_ff;
   logic [PIX_W-1:0] rsp_data_ff;
   logic             adv_a, adv_b, adv_out;

   assign adv_out = !rsp_vld_ff || rsp_tready;
   assign adv_b   = !b_vld_ff || adv_out;
   assign adv_a   = !a_vld_ff || adv_b;

   assign req_pixel = {req_tdata[CH_W-1:0], req_tdata[CH_W +: CH_W],
                       req_tdata[2*CH_W +: CH_W]};

   nmf_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_cmd      (req_tuser),
      .req_pixel    (req_pixel),
      .launch_ready (adv_a),
      .launch       (launch),
      .window       (window)
   );

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      chan_win_type nbr;

      always_comb begin
         for (int i = 0; i < WIN_N; i++) begin
            nbr[i] = window[i][CH_W*(NUM_LANES-1-k) +: CH_W];
         end
      end

      nmf_lane u_lane (
         .clock    (clock),
         .en_a     (adv_a),
         .en_b     (adv_b),
         .nbr      (nbr),
         .use_mask (launch.use_mask),
         .cnt      (launch.cnt),
         .mean     (mean[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (adv_a) begin
            a_vld_ff <= launch.valid;
         end
         if (adv_b) begin
            b_vld_ff <= a_vld_ff;
         end
         if (adv_out) begin
            rsp_vld_ff <= b_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         last_a_ff <= launch.last;
      end
      if (adv_b) begin
         last_b_ff <= last_a_ff;
      end
      if (adv_out) begin
         rsp_last_ff <= last_b_ff;
         rsp_data_ff <= {mean[2], mean[1], mean[0]};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: design/nmf_checker.sv
// ----------------------------------------------------------------------------
// nmf_port_checks
// Port-level checks on the neighbour mean filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nmf_port_checks
   import nmf_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [PIX_W-1:0]      rsp_tdata,
   input wire logic                  rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_PIXEL) |=> !req_tready)
      else $error("pixel item did not occupy the sequencer");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(reset))
      else $error("rsp valid right after reset");

endmodule

bind neighbour_mean_filter_rgb nmf_port_checks u_nmf_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
